>>> rtl/core/dxng_pkg.sv
package dxng_pkg;

   localparam logic [2:0] CSR_ENABLE       = 3'd0;
   localparam logic [2:0] CSR_THRESHOLD    = 3'd1;
   localparam logic [2:0] CSR_FLOOR        = 3'd2;
   localparam logic [2:0] CSR_SLOPE        = 3'd3;
   localparam logic [2:0] CSR_ENV_ATTACK   = 3'd4;
   localparam logic [2:0] CSR_ENV_RELEASE  = 3'd5;
   localparam logic [2:0] CSR_GAIN_ATTACK  = 3'd6;
   localparam logic [2:0] CSR_GAIN_RELEASE = 3'd7;

   localparam logic [16:0] UNITY = 17'd65536;

   typedef logic [15:0][30:0] root_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] bit_w;
      v = value;
      r = '0;
      bit_w = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + bit_w) begin
            v = v - (r + bit_w);
            r = (r >> 1) + bit_w;
         end else begin
            r = r >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return r;
   endfunction

   // Entry k holds 2^(-2^(k-16)) in Q1.30, built by repeated square roots of one half.
   function automatic root_tab_type root_table();
      root_tab_type tab;
      logic [63:0] t;
      t = 64'd1 << 29;
      for (int k = 15; k >= 0; k--) begin
         t = isqrt64(t << 30);
         tab[k] = t[30:0];
      end
      return tab;
   endfunction

endpackage

>>> rtl/core/dxng_req_if.sv
interface dxng_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          channel;
   logic                          block_end;

   modport source (output valid, output sample, output channel, output block_end, input ready);
   modport sink (input valid, input sample, input channel, input block_end, output ready);
endinterface

>>> rtl/core/dxng_rsp_if.sv
interface dxng_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic                          channel_out;
   logic                          block_end_out;

   modport source (output valid, output out_sample, output channel_out, output block_end_out,
                   input ready);
   modport sink (input valid, input out_sample, input channel_out, input block_end_out,
                 output ready);
endinterface

>>> rtl/core/downward_expander_noise_gate.sv
// Below the threshold a result beat follows its input beat through two 16-step logarithms
// and a 16-step exponential; above it or at zero envelope these are skipped, and when disabled
// or for an out-of-range channel the input passes straight through. The next beat is taken the
// cycle after the result beat has left, so no new beat is taken before the last one is through.
// All multiplications run through one shared 32 by 32 multiplier driven by the sequencer.
// Synchronous reset restores register defaults, clears envelopes and sets gains to unity.
module downward_expander_noise_gate
   import dxng_pkg::*;
#(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   dxng_req_if.sink   req_if,
   dxng_rsp_if.source rsp_if,
   input  logic                                          csr_write_en,
   input  logic [2:0]                                    csr_index,
   input  logic [((SAMPLE_BITS-1 > 17) ? SAMPLE_BITS-1 : 17)-1:0] csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int L     = SAMPLE_BITS - 1;
   localparam int PW    = $clog2(SAMPLE_BITS);
   localparam int LOGW  = PW + 16;
   localparam int NW    = PW + 1;
   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [L-1:0] LMAX = {L{1'b1}};
   localparam root_tab_type ROOT_TAB = root_table();

   typedef enum logic [3:0] {
      S_IDLE, S_ENV0, S_ENV1, S_LOGT, S_LOGE, S_EXPO, S_EXPF, S_FIN,
      S_GAIN0, S_GAIN1, S_OUT, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic          enable_ff;
   logic [L-1:0]  thr_ff, floor_ff;
   logic [16:0]   slope_ff;
   logic [15:0]   eatt_ff, erel_ff, gatt_ff, grel_ff;

   logic [L-1:0]  env_ff [CHANNELS];
   logic [16:0]   gain_ff [CHANNELS];

   logic signed [SB-1:0] x_ff, x_in, out_ff, out_in;
   logic [SB-1:0] mag_ff, mag_in;
   logic          ch_ff, ch_in, be_ff, be_in;
   logic [63:0]   acc_ff, acc_in;
   logic [L-1:0]  envc_ff, envc_in;
   logic [16:0]   gt_ff, gt_in, gn_ff, gn_in;
   logic [30:0]   m_ff, m_in, ax_ff, ax_in;
   logic [15:0]   frac_ff, frac_in, f_ff, f_in;
   logic [PW-1:0] p_ff, p_in;
   logic [LOGW-1:0] lt_ff, lt_in, d_ff, d_in;
   logic [NW-1:0] n_ff, n_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          env_we, gain_we;

   logic [CW-1:0] idx;
   logic [L-1:0]  env_old, a_lim;
   logic [16:0]   g_old, fl, c_env, c_gain;
   logic [31:0]   mul_a, mul_b;
   logic [63:0]   prod;
   logic [L+17:0] fl_wide;

   function automatic logic [PW-1:0] lead_one(input logic [L-1:0] v);
      logic [PW-1:0] p;
      p = '0;
      for (int i = 0; i < L; i++) begin
         if (v[i]) begin
            p = PW'(i);
         end
      end
      return p;
   endfunction

   function automatic logic [30:0] mant_init(input logic [L-1:0] v, input logic [PW-1:0] p);
      return 31'(31'(v) << (6'd30 - 6'(p)));
   endfunction

   function automatic logic [16:0] clamp_gain(input logic [16:0] g, input logic [16:0] fmin);
      logic [16:0] t;
      t = (g < fmin) ? fmin : g;
      return (t > UNITY) ? UNITY : t;
   endfunction

   assign idx     = CW'(ch_ff);
   assign env_old = env_ff[idx];
   assign g_old   = gain_ff[idx];
   assign a_lim   = (mag_ff > SB'(LMAX)) ? LMAX : mag_ff[L-1:0];
   assign c_env   = {1'b0, (a_lim > env_old) ? eatt_ff : erel_ff};
   assign c_gain  = {1'b0, (gt_ff > g_old) ? gatt_ff : grel_ff};
   assign fl_wide = ((L+18)'(floor_ff) << 16) + ((L+18)'(1) << (L - 1));
   assign fl      = 17'(fl_wide >> L);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_ENV0: begin
            mul_a = 32'(c_env);
            mul_b = 32'(env_old);
         end
         S_ENV1: begin
            mul_a = 32'(UNITY - c_env);
            mul_b = 32'(a_lim);
         end
         S_LOGT, S_LOGE: begin
            mul_a = 32'(m_ff);
            mul_b = 32'(m_ff);
         end
         S_EXPO: begin
            mul_a = 32'(d_ff);
            mul_b = 32'(slope_ff);
         end
         S_EXPF: begin
            mul_a = 32'(ax_ff);
            mul_b = 32'(ROOT_TAB[cnt_ff]);
         end
         S_GAIN0: begin
            mul_a = 32'(c_gain);
            mul_b = 32'(g_old);
         end
         S_GAIN1: begin
            mul_a = 32'(UNITY - c_gain);
            mul_b = 32'(gt_ff);
         end
         S_OUT: begin
            mul_a = 32'(mag_ff);
            mul_b = 32'(gn_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      logic [31:0]  q;
      logic [15:0]  frac_nx;
      logic [63:0]  sum;
      logic [63:0]  ep;
      logic [5:0]   sh;
      logic [32:0]  r33;
      logic signed [63:0] ps;
      logic signed [63:0] yy;
      state_in = state_ff;
      x_in     = x_ff;
      out_in   = out_ff;
      mag_in   = mag_ff;
      ch_in    = ch_ff;
      be_in    = be_ff;
      acc_in   = acc_ff;
      envc_in  = envc_ff;
      gt_in    = gt_ff;
      gn_in    = gn_ff;
      m_in     = m_ff;
      ax_in    = ax_ff;
      frac_in  = frac_ff;
      f_in     = f_ff;
      p_in     = p_ff;
      lt_in    = lt_ff;
      d_in     = d_ff;
      n_in     = n_ff;
      cnt_in   = cnt_ff;
      env_we   = 1'b0;
      gain_we  = 1'b0;
      q        = prod[61:30];
      frac_nx  = frac_ff | (16'(q[31]) << cnt_ff);
      sum      = '0;
      ep       = '0;
      sh       = '0;
      r33      = '0;
      ps       = '0;
      yy       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               x_in   = req_if.sample;
               ch_in  = req_if.channel;
               be_in  = req_if.block_end;
               mag_in = req_if.sample[SB-1] ? SB'(-req_if.sample) : SB'(req_if.sample);
               if (enable_ff && (32'(req_if.channel) < 32'(CHANNELS))) begin
                  state_in = S_ENV0;
               end else begin
                  out_in   = req_if.sample;
                  state_in = S_DONE;
               end
            end
         end
         S_ENV0: begin
            acc_in   = prod;
            state_in = S_ENV1;
         end
         S_ENV1: begin
            sum     = acc_ff + prod + 64'd32768;
            envc_in = sum[16 +: L];
            env_we  = 1'b1;
            if (sum[16 +: L] >= thr_ff) begin
               gt_in    = UNITY;
               state_in = S_GAIN0;
            end else if (sum[16 +: L] == '0) begin
               gt_in    = clamp_gain((slope_ff == '0) ? UNITY : 17'd0, fl);
               state_in = S_GAIN0;
            end else begin
               p_in     = lead_one(thr_ff);
               m_in     = mant_init(thr_ff, lead_one(thr_ff));
               frac_in  = '0;
               cnt_in   = 4'd15;
               state_in = S_LOGT;
            end
         end
         S_LOGT, S_LOGE: begin
            m_in    = q[31] ? q[31:1] : q[30:0];
            frac_in = frac_nx;
            cnt_in  = cnt_ff - 4'd1;
            if (cnt_ff == '0) begin
               if (state_ff == S_LOGT) begin
                  lt_in    = {p_ff, frac_nx};
                  p_in     = lead_one(envc_ff);
                  m_in     = mant_init(envc_ff, lead_one(envc_ff));
                  frac_in  = '0;
                  cnt_in   = 4'd15;
                  state_in = S_LOGE;
               end else begin
                  d_in     = lt_ff - {p_ff, frac_nx};
                  state_in = S_EXPO;
               end
            end
         end
         S_EXPO: begin
            ep       = prod + 64'd32768;
            f_in     = ep[31:16];
            n_in     = ep[LOGW+16:32];
            ax_in    = 31'd1 << 30;
            cnt_in   = 4'd15;
            state_in = S_EXPF;
         end
         S_EXPF: begin
            if (f_ff[cnt_ff]) begin
               ax_in = 31'((prod + (64'd1 << 29)) >> 30);
            end
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == '0) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (32'(n_ff) > 32'd17) begin
               r33 = '0;
            end else begin
               sh  = 6'd14 + 6'(n_ff);
               r33 = (33'(ax_ff) + (33'd1 << (sh - 6'd1))) >> sh;
            end
            gt_in    = clamp_gain(17'(r33), fl);
            state_in = S_GAIN0;
         end
         S_GAIN0: begin
            acc_in   = prod;
            state_in = S_GAIN1;
         end
         S_GAIN1: begin
            sum      = acc_ff + prod + 64'd32768;
            gn_in    = sum[32:16];
            gain_we  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            ps = x_ff[SB-1] ? -$signed(prod) : $signed(prod);
            yy = (ps + 64'sd32768) >>> 16;
            if (yy > $signed(64'(LMAX))) begin
               out_in = SB'(LMAX);
            end else if (yy < -(64'sd1 <<< L)) begin
               out_in = {1'b1, {L{1'b0}}};
            end else begin
               out_in = SB'(yy);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         enable_ff <= 1'b1;
         thr_ff    <= L'(83886);
         floor_ff  <= L'(838861);
         slope_ff  <= 17'd32768;
         eatt_ff   <= 16'd64880;
         erel_ff   <= 16'd65470;
         gatt_ff   <= 16'd64880;
         grel_ff   <= 16'd65470;
         for (int i = 0; i < CHANNELS; i++) begin
            env_ff[i]  <= '0;
            gain_ff[i] <= UNITY;
         end
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_ENABLE:       enable_ff <= csr_wdata[0];
               CSR_THRESHOLD:    thr_ff    <= csr_wdata[L-1:0];
               CSR_FLOOR:        floor_ff  <= csr_wdata[L-1:0];
               CSR_SLOPE:        slope_ff  <= csr_wdata[16:0];
               CSR_ENV_ATTACK:   eatt_ff   <= csr_wdata[15:0];
               CSR_ENV_RELEASE:  erel_ff   <= csr_wdata[15:0];
               CSR_GAIN_ATTACK:  gatt_ff   <= csr_wdata[15:0];
               CSR_GAIN_RELEASE: grel_ff   <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
         if (env_we) begin
            env_ff[idx] <= envc_in;
         end
         if (gain_we) begin
            gain_ff[idx] <= gn_in;
         end
      end
      x_ff    <= x_in;
      out_ff  <= out_in;
      mag_ff  <= mag_in;
      ch_ff   <= ch_in;
      be_ff   <= be_in;
      acc_ff  <= acc_in;
      envc_ff <= envc_in;
      gt_ff   <= gt_in;
      gn_ff   <= gn_in;
      m_ff    <= m_in;
      ax_ff   <= ax_in;
      frac_ff <= frac_in;
      f_ff    <= f_in;
      p_ff    <= p_in;
      lt_ff   <= lt_in;
      d_ff    <= d_in;
      n_ff    <= n_in;
      cnt_ff  <= cnt_in;
   end

   assign req_if.ready         = (state_ff == S_IDLE);
   assign rsp_if.valid         = (state_ff == S_DONE);
   assign rsp_if.out_sample    = out_ff;
   assign rsp_if.channel_out   = ch_ff;
   assign rsp_if.block_end_out = be_ff;

`ifndef ASSERT_OFF
   // A result beat and a new input beat never overlap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("input ready while a result is pending");

   // Once a beat is taken, the block stays busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("input taken twice in a row");

   // Delivering the result returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready) |=> req_if.ready)
      else $error("sequencer did not return to idle");

   // The target gain fed to the smoother never exceeds unity.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GAIN0) |-> (gt_ff <= UNITY))
      else $error("target gain above unity");
`endif

endmodule

>>> tb/downward_expander_noise_gate_test.sv
module downward_expander_noise_gate_test;
   import dxng_pkg::*;

   localparam int SB = 24;
   localparam int CW = 23;
   localparam longint LMASK = (64'd1 << (SB - 1)) - 1;
   localparam longint MAX_CYCLES = 600000;

   typedef struct packed {
      logic signed [SB-1:0] smp;
      logic                 chan;
      logic                 bend;
   } audio_beat_type;

   class gate_scoreboard;
      audio_beat_type   pending_q[$];
      logic             en;
      logic [22:0]      thresh;
      logic [22:0]      floor_lvl;
      logic [16:0]      slope;
      logic [15:0]      env_att, env_rel, gain_att, gain_rel;
      longint unsigned  env_st[2];
      longint unsigned  gain_st[2];
      int               errors;

      function void init();
         en = 1; thresh = 83886; floor_lvl = 838861; slope = 32768;
         env_att = 64880; env_rel = 65470; gain_att = 64880; gain_rel = 65470;
         for (int i = 0; i < 2; i++) begin
            env_st[i] = 0;
            gain_st[i] = 65536;
         end
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, longint unsigned v);
         case (idx)
            CSR_ENABLE:       en = v[0];
            CSR_THRESHOLD:    thresh = v[22:0];
            CSR_FLOOR:        floor_lvl = v[22:0];
            CSR_SLOPE:        slope = v[16:0];
            CSR_ENV_ATTACK:   env_att = v[15:0];
            CSR_ENV_RELEASE:  env_rel = v[15:0];
            CSR_GAIN_ATTACK:  gain_att = v[15:0];
            CSR_GAIN_RELEASE: gain_rel = v[15:0];
            default: ;
         endcase
      endfunction

      function longint unsigned int_root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function longint unsigned log2_fix(longint unsigned v);
         longint unsigned p, m, fr;
         p = 0;
         fr = 0;
         while (p < 62 && (v >> (p + 1)) != 0) p++;
         m = v << (30 - p);
         for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
               m >>= 1;
               fr |= 64'd1 << i;
            end
         end
         return (p << 16) | fr;
      endfunction

      function longint unsigned pow2_neg(longint unsigned e);
         longint unsigned n, f, acc, t, s;
         n = e >> 16;
         f = e & 16'hFFFF;
         acc = 64'd1 << 30;
         t = 64'd1 << 29;
         for (int b = 15; b >= 0; b--) begin
            t = int_root(t << 30);
            if ((f >> b) & 1) acc = (acc * t + (64'd1 << 29)) >> 30;
         end
         s = 14 + n;
         if (s >= 62) return 0;
         return (acc + (64'd1 << (s - 1))) >> s;
      endfunction

      function longint unsigned one_pole(longint unsigned y, longint unsigned x,
                                         longint unsigned c);
         return (c * y + (65536 - c) * x + 32768) >> 16;
      endfunction

      function logic signed [SB-1:0] gated_sample(audio_beat_type b);
         longint x, y, p;
         longint unsigned a, env, gt, g, fl, d, e;
         x = b.smp;
         y = x;
         if (en) begin
            a = (x < 0) ? -x : x;
            if (a > LMASK) a = LMASK;
            env = env_st[b.chan];
            env = one_pole(env, a, a > env ? env_att : env_rel);
            env_st[b.chan] = env;
            gt = 65536;
            if (env < thresh) begin
               fl = ((longint'(floor_lvl) << 16) + (64'd1 << (SB - 2))) >> (SB - 1);
               if (env == 0) begin
                  gt = (slope == 0) ? 65536 : 0;
               end else begin
                  d = log2_fix(thresh) - log2_fix(env);
                  e = (d * slope + 32768) >> 16;
                  gt = pow2_neg(e);
               end
               if (gt < fl) gt = fl;
               if (gt > 65536) gt = 65536;
            end
            g = gain_st[b.chan];
            g = one_pole(g, gt, gt > g ? gain_att : gain_rel);
            gain_st[b.chan] = g;
            p = x * longint'(g) + 32768;
            if (p >= 0) y = p / 65536;
            else y = -((-p + 65535) / 65536);
            if (y < -LMASK - 1) y = -LMASK - 1;
            if (y > LMASK) y = LMASK;
         end
         return y[SB-1:0];
      endfunction

      function void note_input(audio_beat_type b);
         audio_beat_type r;
         r = b;
         r.smp = gated_sample(b);
         pending_q.push_back(r);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(audio_beat_type got);
         audio_beat_type w;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected beat %h", got));
         end else begin
            w = pending_q.pop_front();
            if (got.smp !== w.smp)
               report($sformatf("out_sample %0d, expected %0d", got.smp, w.smp));
            if (got.chan !== w.chan)
               report($sformatf("channel_out %b, expected %b", got.chan, w.chan));
            if (got.bend !== w.bend)
               report($sformatf("block_end_out %b, expected %b", got.bend, w.bend));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [2:0] csr_index;
   logic [CW-1:0] csr_wdata;
   longint cycle_count;
   int sent;
   bit hold_off;
   bit no_idle;
   gate_scoreboard sb;

   dxng_req_if #(.SAMPLE_BITS(SB)) req_if ();
   dxng_rsp_if #(.SAMPLE_BITS(SB)) rsp_if ();

   downward_expander_noise_gate #(.CHANNELS(2), .SAMPLE_BITS(SB)) u_top (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > MAX_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result({rsp_if.out_sample, rsp_if.channel_out, rsp_if.block_end_out});
         rsp_if.ready <= !hold_off && (no_idle || $urandom_range(99) >= 11);
      end
   end

   task send_beat(logic signed [SB-1:0] s, logic c, logic e);
      if (!no_idle) begin
         while ($urandom_range(99) < 11) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid <= 1'b1;
      req_if.sample <= s;
      req_if.channel <= c;
      req_if.block_end <= e;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_input({s, c, e});
      sent++;
   endtask

   task write_csr(logic [2:0] idx, longint unsigned v);
      req_if.valid <= 1'b0;
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[CW-1:0];
      @(posedge clock);
      sb.write_reg(idx, v);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task drain();
      req_if.valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function logic signed [SB-1:0] rand_sample(int mode);
      case (mode)
         0: return SB'($urandom);
         1: return $signed(SB'($urandom_range(4000))) - 24'sd2000;
         2: return $signed(SB'($urandom_range(200000))) - 24'sd100000;
         default: return ($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000;
      endcase
   endfunction

   task random_burst(int n);
      int mode;
      mode = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(15) == 0) mode = $urandom_range(3);
         send_beat(rand_sample(mode), 1'($urandom_range(1)), $urandom_range(7) == 0);
      end
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task random_settings();
      write_csr(CSR_THRESHOLD, $urandom_range(3) == 0 ? $urandom : $urandom_range(200000, 1));
      write_csr(CSR_FLOOR, $urandom);
      write_csr(CSR_SLOPE, $urandom_range(65536, 3277));
      write_csr(CSR_ENV_ATTACK, $urandom);
      write_csr(CSR_ENV_RELEASE, $urandom);
      write_csr(CSR_GAIN_ATTACK, $urandom);
      write_csr(CSR_GAIN_RELEASE, $urandom);
      write_csr(CSR_ENABLE, $urandom_range(5) != 0);
   endtask

   initial begin
      sb = new();
      sb.init();
      sent = 0;
      hold_off = 0;
      no_idle = 0;
      reset = 1;
      csr_write_en = 0;
      csr_index = CSR_ENABLE;
      csr_wdata = '0;
      req_if.valid = 0;
      req_if.sample = '0;
      req_if.channel = 0;
      req_if.block_end = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed beats at default settings: silence, extremes and small levels.
      send_beat(0, 0, 0);
      send_beat(24'sh7FFFFF, 0, 1);
      send_beat(24'sh800000, 1, 0);
      send_beat(1, 1, 1);
      send_beat(-1, 0, 0);
      send_beat(1000, 0, 0);
      send_beat(0, 1, 1);
      drain();
      // Pass-through when disabled.
      write_csr(CSR_ENABLE, 0);
      send_beat(24'sh800000, 0, 1);
      send_beat(12345, 1, 0);
      drain();
      // Zero slope with silence gives unity; zero threshold never expands.
      write_csr(CSR_ENABLE, 1);
      write_csr(CSR_SLOPE, 0);
      send_beat(0, 0, 0);
      drain();
      write_csr(CSR_SLOPE, 17'h1FFFF);
      write_csr(CSR_ENV_ATTACK, 0);
      write_csr(CSR_ENV_RELEASE, 0);
      write_csr(CSR_GAIN_ATTACK, 0);
      write_csr(CSR_GAIN_RELEASE, 0);
      write_csr(CSR_FLOOR, 0);
      send_beat(3, 1, 0);
      send_beat(-500, 0, 1);
      send_beat(0, 1, 0);
      drain();
      write_csr(CSR_THRESHOLD, 0);
      write_csr(CSR_FLOOR, LMASK);
      write_csr(CSR_ENV_ATTACK, 65535);
      write_csr(CSR_ENV_RELEASE, 65535);
      write_csr(CSR_GAIN_ATTACK, 65535);
      write_csr(CSR_GAIN_RELEASE, 65535);
      send_beat(77, 0, 0);
      send_beat(24'sh7FFFFF, 1, 1);
      drain();
      write_csr(CSR_THRESHOLD, LMASK);
      write_csr(CSR_SLOPE, 65536);
      write_csr(CSR_FLOOR, 0);
      send_beat(24'sh7FFFFE, 0, 0);
      send_beat(-8, 1, 0);
      drain();

      // Long stall on the result side so the input backs up.
      hold_off = 1;
      fork
         random_burst(20);
         begin
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
      join
      drain();

      no_idle = 1;
      random_burst(150);
      no_idle = 0;
      drain();

      while (sent < 1270) begin
         random_settings();
         random_burst($urandom_range(150, 60));
         drain();
      end

      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
